>>> hdl/vtyp_pkg.sv
// Shared constants for the vector to yaw/pitch converter: angle widths,
// fixed-point scaling and the CORDIC arctangent table in binary angle units.
// No dependencies.
package vtyp_pkg;

    localparam int FRAC_BITS  = 24;   // fraction bits of the CORDIC datapath
    localparam int TABLE_LEN  = 24;
    localparam int ANGLE_BITS = 16;   // output angle width
    localparam int ACC_W      = 18;   // accumulator values lie within about -18182 .. 50950

    localparam logic signed [ACC_W-1:0] HALF_TURN    = 18'sd32768;
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 18'sd16384;

    // atan(2^-i) rounded to 65536 units per turn
    localparam logic [13:0] ATAN_UNITS [0:TABLE_LEN-1] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0,
        14'd0,    14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0,   14'd0
    };

endpackage

>>> hdl/vector_to_yaw_pitch_unit.sv
// Vector to yaw/pitch converter: two unrolled CORDIC vectoring lanes, one step per stage.
// Depends on vtyp_pkg.
//
//   channel | ports                                   | dir | meaning
//   --------+-----------------------------------------+-----+-----------------------------
//   s_      | s_valid s_ready s_vec_x s_vec_y s_vec_z | in  | vector request (x, y, z)
//   m_      | m_valid m_ready m_yaw m_pitch           | out | yaw and pitch result
//
// Stages: input stage, one stage per CORDIC step, output register. One request is taken
// every cycle unless the output stalls. The stage count is set by the depth of the
// unrolled CORDIC step chain. Each stage holds while its successor is full and stalled,
// so bubbles close up and s_ready drops only when every stage holds a request.
// Reset (aresetn, synchronous, active low) clears the valid bits only.
module vector_to_yaw_pitch_unit #(
    parameter int ITERATIONS     = 16,
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [COMPONENT_BITS-1:0]          s_vec_x,
    input  logic signed [COMPONENT_BITS-1:0]          s_vec_y,
    input  logic signed [COMPONENT_BITS-1:0]          s_vec_z,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic        [vtyp_pkg::ANGLE_BITS-1:0]    m_yaw,
    output logic signed [vtyp_pkg::ANGLE_BITS-1:0]    m_pitch
);
    import vtyp_pkg::*;

    localparam int W     = COMPONENT_BITS + FRAC_BITS + 3;
    localparam int NSTEP = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    // stage 0 is the input register, stage k holds the result of step k-1
    logic signed [W-1:0]     ya_reg   [0:NSTEP];
    logic signed [W-1:0]     xb_reg   [0:NSTEP];
    logic signed [W-1:0]     pa_reg   [0:NSTEP];
    logic signed [W-1:0]     pb_reg   [0:NSTEP];
    logic signed [ACC_W-1:0] yacc_reg [0:NSTEP];
    logic signed [ACC_W-1:0] pacc_reg [0:NSTEP];
    logic                    yzero_reg[0:NSTEP];
    logic                    pzero_reg[0:NSTEP];
    logic                    zneg_reg [0:NSTEP];
    logic                    vld_reg  [0:NSTEP];
    logic                    en       [0:NSTEP];

    logic                              out_vld_reg;
    logic        [ANGLE_BITS-1:0]      yaw_reg;
    logic signed [ANGLE_BITS-1:0]      pitch_reg;
    logic                              out_en;

    // ---------------- front end: sign handling and prerotation ----------------
    logic signed [W-1:0]     xw, yw, zw, ax, ay, az, horiz;
    logic signed [W-1:0]     ya_next, xb_next, pa_next, pb_next;
    logic signed [ACC_W-1:0] yacc_next;

    always_comb begin
        xw    = W'(s_vec_x);
        yw    = W'(s_vec_y);
        zw    = W'(s_vec_z);
        ax    = xw[W-1] ? -xw : xw;
        ay    = yw[W-1] ? -yw : yw;
        az    = zw[W-1] ? -zw : zw;
        horiz = (ax > ay) ? ax : ay;
        // yaw: angle of point (y, x); left half plane turned by a half turn
        if (yw[W-1]) begin
            ya_next   = -(xw <<< FRAC_BITS);
            xb_next   = -(yw <<< FRAC_BITS);
            yacc_next = HALF_TURN;
        end else begin
            ya_next   = xw <<< FRAC_BITS;
            xb_next   = yw <<< FRAC_BITS;
            yacc_next = '0;
        end
        // pitch: angle of point (horiz, |z|), always in the right half plane
        pa_next = az <<< FRAC_BITS;
        pb_next = horiz <<< FRAC_BITS;
    end

    assign out_en  = !out_vld_reg || m_ready;
    assign s_ready = en[0];

    always_comb begin
        for (int k = 0; k < NSTEP; k++) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        en[NSTEP] = !vld_reg[NSTEP] || out_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en[0]) begin
            vld_reg[0] <= s_valid;
        end
        if (en[0] && s_valid) begin
            ya_reg[0]    <= ya_next;
            xb_reg[0]    <= xb_next;
            pa_reg[0]    <= pa_next;
            pb_reg[0]    <= pb_next;
            yacc_reg[0]  <= yacc_next;
            pacc_reg[0]  <= '0;
            yzero_reg[0] <= (s_vec_x == '0) && (s_vec_y == '0);
            pzero_reg[0] <= (s_vec_x == '0) && (s_vec_y == '0) && (s_vec_z == '0);
            zneg_reg[0]  <= s_vec_z[COMPONENT_BITS-1];
        end
    end

    // ---------------- CORDIC steps, one per stage ----------------
    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        localparam int I = k - 1;
        localparam logic signed [ACC_W-1:0] ANG = signed'(ACC_W'(ATAN_UNITS[I]));

        logic signed [W-1:0]     ya_sh, xb_sh, pa_sh, pb_sh;
        logic signed [W-1:0]     ya_n, xb_n, pa_n, pb_n;
        logic signed [ACC_W-1:0] yacc_n, pacc_n;

        always_comb begin
            ya_sh = ya_reg[k-1] >>> I;
            xb_sh = xb_reg[k-1] >>> I;
            pa_sh = pa_reg[k-1] >>> I;
            pb_sh = pb_reg[k-1] >>> I;
            if (!ya_reg[k-1][W-1]) begin
                xb_n   = xb_reg[k-1] + ya_sh;
                ya_n   = ya_reg[k-1] - xb_sh;
                yacc_n = yacc_reg[k-1] + ANG;
            end else begin
                xb_n   = xb_reg[k-1] - ya_sh;
                ya_n   = ya_reg[k-1] + xb_sh;
                yacc_n = yacc_reg[k-1] - ANG;
            end
            if (!pa_reg[k-1][W-1]) begin
                pb_n   = pb_reg[k-1] + pa_sh;
                pa_n   = pa_reg[k-1] - pb_sh;
                pacc_n = pacc_reg[k-1] + ANG;
            end else begin
                pb_n   = pb_reg[k-1] - pa_sh;
                pa_n   = pa_reg[k-1] + pb_sh;
                pacc_n = pacc_reg[k-1] - ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en[k]) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en[k] && vld_reg[k-1]) begin
                ya_reg[k]    <= ya_n;
                xb_reg[k]    <= xb_n;
                pa_reg[k]    <= pa_n;
                pb_reg[k]    <= pb_n;
                yacc_reg[k]  <= yacc_n;
                pacc_reg[k]  <= pacc_n;
                yzero_reg[k] <= yzero_reg[k-1];
                pzero_reg[k] <= pzero_reg[k-1];
                zneg_reg[k]  <= zneg_reg[k-1];
            end
        end
    end

    // ---------------- output: wrap, clamp and sign ----------------
    logic        [ANGLE_BITS-1:0] yaw_next;
    logic signed [ACC_W-1:0]      pmag;
    logic signed [ANGLE_BITS-1:0] pitch_next;

    always_comb begin
        yaw_next = yzero_reg[NSTEP] ? '0 : yacc_reg[NSTEP][ANGLE_BITS-1:0];
        if (pzero_reg[NSTEP] || pacc_reg[NSTEP][ACC_W-1]) begin
            pmag = '0;
        end else if (pacc_reg[NSTEP] > QUARTER_TURN) begin
            pmag = QUARTER_TURN;
        end else begin
            pmag = pacc_reg[NSTEP];
        end
        pitch_next = zneg_reg[NSTEP] ? -pmag[ANGLE_BITS-1:0] : pmag[ANGLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_en) begin
            out_vld_reg <= vld_reg[NSTEP];
        end
        if (out_en && vld_reg[NSTEP]) begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_yaw   = yaw_reg;
    assign m_pitch = pitch_reg;

    // ---------------- checks ----------------
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch >= -16'sd16384) && (m_pitch <= 16'sd16384))
        else $error("pitch outside a quarter turn");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && vld_reg[0] && vld_reg[NSTEP])
        else $error("input stalled with room in the pipeline");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !vld_reg[0])
        else $error("valid bits not cleared by reset");

endmodule

>>> bench/testbench.sv
// Self-checking bench for vector_to_yaw_pitch_unit: directed and random vectors,
// with expected yaw/pitch from a CORDIC angle predictor in this file.
// Depends on vtyp_pkg and the vector_to_yaw_pitch_unit RTL.
`timescale 1ns / 100ps

module testbench;

    import vtyp_pkg::*;

    localparam int ITERATIONS     = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int CB             = COMPONENT_BITS;
    localparam int RANDOM_VECTORS = 800;
    localparam int QUIET_TAIL     = 100;   // last random vectors run with no idling
    localparam int FLOOD_VECTORS  = 60;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 2000;  // cycles with no request moving on either side
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        int x;
        int y;
        int z;
        bit known;
        int yaw;
        int pitch;
    } vec_case_t;

    typedef struct {
        logic signed [CB-1:0]         x;
        logic signed [CB-1:0]         y;
        logic signed [CB-1:0]         z;
        logic [ANGLE_BITS-1:0]        yaw;
        logic signed [ANGLE_BITS-1:0] pitch;
    } heading_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [CB-1:0]         s_vec_x;
    logic signed [CB-1:0]         s_vec_y;
    logic signed [CB-1:0]         s_vec_z;
    logic                         m_valid;
    logic                         m_ready;
    logic [ANGLE_BITS-1:0]        m_yaw;
    logic signed [ANGLE_BITS-1:0] m_pitch;

    // typed-in answer travels with the request it belongs to
    bit                           typed_known;
    logic [ANGLE_BITS-1:0]        typed_yaw;
    logic signed [ANGLE_BITS-1:0] typed_pitch;

    heading_t pending_headings[$];
    int       mismatches;
    int       results_checked;
    int       vectors_sent;
    int       idle_cycles;
    int       long_holds;
    int       drains;
    bit       hold_req;
    bit       no_idling;

    // zero vector is the only row whose answer is plain from the spec
    vec_case_t directed_cases[22] = '{
        '{0, 0, 0, 1, 0, 0},
        '{0, 1, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0},
        '{0, -1, 0, 0, 0, 0},
        '{-1, 0, 0, 0, 0, 0},
        '{32767, 32767, 32767, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 0, 0},
        '{-32768, 0, 0, 0, 0, 0},
        '{0, -32768, 0, 0, 0, 0},
        '{32767, 0, 0, 0, 0, 0},
        '{0, 32767, 0, 0, 0, 0},
        '{0, 0, 32767, 0, 0, 0},
        '{0, 0, -32768, 0, 0, 0},
        '{0, 0, 1, 0, 0, 0},
        '{0, 0, -1, 0, 0, 0},
        '{1, 1, 0, 0, 0, 0},
        '{-1, -1, -1, 0, 0, 0},
        '{100, -100, 50, 0, 0, 0},
        '{-32768, 32767, 0, 0, 0, 0},
        '{32767, -32768, -1, 0, 0, 0},
        '{5, 0, -32768, 0, 0, 0},
        '{-3, 7, 32767, 0, 0, 0}
    };

    vector_to_yaw_pitch_unit #(
        .ITERATIONS     (ITERATIONS),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_vec_x (s_vec_x),
        .s_vec_y (s_vec_y),
        .s_vec_z (s_vec_z),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_yaw   (m_yaw),
        .m_pitch (m_pitch)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Angle of point (den, num) in binary angle units, vectoring CORDIC.
    function automatic int cordic_angle(input longint num, input longint den);
        longint ya;
        longint xb;
        longint na;
        longint nb;
        int     acc;
        acc = 0;
        if (num == 0 && den == 0)
            return 0;
        ya = num * (64'sd1 <<< FRAC_BITS);
        xb = den * (64'sd1 <<< FRAC_BITS);
        if (xb < 0) begin
            xb  = -xb;
            ya  = -ya;
            acc = 32768;
        end
        for (int i = 0; i < ITERATIONS && i < TABLE_LEN; i++) begin
            if (ya >= 0) begin
                nb  = xb + (ya >>> i);
                na  = ya - (xb >>> i);
                acc = acc + int'(ATAN_UNITS[i]);
            end else begin
                nb  = xb - (ya >>> i);
                na  = ya + (xb >>> i);
                acc = acc - int'(ATAN_UNITS[i]);
            end
            xb = nb;
            ya = na;
        end
        return acc;
    endfunction

    function automatic heading_t predict_heading(input logic signed [CB-1:0] x,
                                                 input logic signed [CB-1:0] y,
                                                 input logic signed [CB-1:0] z);
        heading_t h;
        longint   ax;
        longint   ay;
        longint   az;
        int       yaw_acc;
        int       pitch_acc;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        az = (z < 0) ? -longint'(z) : longint'(z);
        yaw_acc   = cordic_angle(longint'(x), longint'(y));
        pitch_acc = cordic_angle(az, (ax > ay) ? ax : ay);
        if (pitch_acc < 0)
            pitch_acc = 0;
        if (pitch_acc > 16384)
            pitch_acc = 16384;
        if (z < 0)
            pitch_acc = -pitch_acc;
        h.x     = x;
        h.y     = y;
        h.z     = z;
        h.yaw   = yaw_acc[ANGLE_BITS-1:0];
        h.pitch = pitch_acc[ANGLE_BITS-1:0];
        return h;
    endfunction

    function automatic int random_component();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return int'($urandom_range(0, (1 << CB) - 1)) - (1 << (CB - 1));
        else if (pick < 17)
            return int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 4))
            0: return -(1 << (CB - 1));
            1: return (1 << (CB - 1)) - 1;
            2: return -1;
            3: return 1;
            default: return 0;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input heading_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: vec (%0d,%0d,%0d) expected yaw %0d pitch %0d, got yaw %0d pitch %0d",
                     $time, what, want.x, want.y, want.z, want.yaw, want.pitch, m_yaw, m_pitch);
    endtask

    // One request on the input side; idles first now and then unless told not to.
    task automatic offer_vector(input int x, input int y, input int z,
                                input bit known, input int kyaw, input int kpitch);
        @(negedge aclk);
        if (!no_idling && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_vec_x     <= x[CB-1:0];
        s_vec_y     <= y[CB-1:0];
        s_vec_z     <= z[CB-1:0];
        typed_known <= known;
        typed_yaw   <= kyaw[ANGLE_BITS-1:0];
        typed_pitch <= kpitch[ANGLE_BITS-1:0];
        s_valid     <= 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        vectors_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge aclk);
        drains++;
    endtask

    // Result side: check before queueing this edge's request, so an early result
    // can never be matched against a request taken in the same cycle.
    always @(posedge aclk) begin
        heading_t want;
        heading_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (pending_headings.size() == 0) begin
                    got = '{default: '0};
                    note_mismatch("result with nothing pending", got);
                end else begin
                    want = pending_headings.pop_front();
                    if (m_yaw !== want.yaw || m_pitch !== want.pitch)
                        note_mismatch("yaw/pitch mismatch", want);
                end
            end
            if (s_valid && s_ready) begin
                want = predict_heading(s_vec_x, s_vec_y, s_vec_z);
                if (typed_known) begin
                    want.yaw   = typed_yaw;
                    want.pitch = typed_pitch;
                end
                pending_headings.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles, %0d results pending",
                     idle_cycles, pending_headings.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Result acceptor: random stall bursts, plus one long hold on request.
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && long_holds == 0) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_holds++;
            end else if (!no_idling && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_vec_x     = '0;
        s_vec_y     = '0;
        s_vec_z     = '0;
        typed_known = 1'b0;
        typed_yaw   = '0;
        typed_pitch = '0;
        hold_req    = 1'b0;
        no_idling   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[i])
            offer_vector(directed_cases[i].x, directed_cases[i].y, directed_cases[i].z,
                         directed_cases[i].known, directed_cases[i].yaw,
                         directed_cases[i].pitch);
        drain_results();

        // back up the whole pipe: output held while input keeps coming
        hold_req  = 1'b1;
        no_idling = 1'b1;
        repeat (FLOOD_VECTORS)
            offer_vector(random_component(), random_component(), random_component(),
                         1'b0, 0, 0);
        no_idling = 1'b0;
        drain_results();

        for (int n = 0; n < RANDOM_VECTORS; n++) begin
            no_idling = (n >= RANDOM_VECTORS - QUIET_TAIL);
            offer_vector(random_component(), random_component(), random_component(),
                         1'b0, 0, 0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_headings.size() != 0)
            @(posedge aclk);
        repeat (ITERATIONS + 4) @(posedge aclk);

        $display("%0d vectors sent (directed extremes, a full-pipe backlog, random mix),",
                 vectors_sent);
        $display("%0d results checked, %0d long hold(s), %0d drain pause(s), %0d mismatches",
                 results_checked, long_holds, drains, mismatches);
        if (mismatches == 0 && pending_headings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> vector_to_yaw_pitch_unit.f
hdl/vtyp_pkg.sv
hdl/vector_to_yaw_pitch_unit.sv
bench/testbench.sv
